### hw/rtl/iirtdf_pkg.sv
`default_nettype none

package iirtdf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 18;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int DLY_W        = 40;
  localparam int ACC_W        = DLY_W + 2;
  localparam int FRAC         = 14;
  localparam int YSH_W        = ACC_W - FRAC;
  localparam int NUM_COEF     = 7;
  localparam int NUM_DLY      = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int TAPS_DEFAULT = 4;
  localparam int PC_W         = 4;

  // register indexes, also the multiplier coefficient select
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd6;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd16384;

  // accumulator operations
  localparam logic [1:0] ACC_NOP = 2'd0;
  localparam logic [1:0] ACC_OUT = 2'd1;  // acc = prod + d0 + half lsb
  localparam logic [1:0] ACC_DLY = 2'd2;  // acc = prod + d[tap]
  localparam logic [1:0] ACC_WR  = 2'd3;  // d[tap-1] = clamp(acc - prod)

  typedef struct packed {
    logic                 mul_en;
    logic [CFG_IDX_W-1:0] mul_sel;
    logic                 mul_y;
    logic [1:0]           acc_op;
    logic [1:0]           tap;
    logic                 y_ld;
    logic                 fin_last;
    logic                 fin;
  } ctrl_t;

  typedef struct packed {
    logic  en;
    ctrl_t ctrl;
  } step_t;

  function automatic ctrl_t uop(logic mul_en, logic [CFG_IDX_W-1:0] mul_sel, logic mul_y,
                                logic [1:0] acc_op, logic [1:0] tap, logic y_ld,
                                logic fin_last, logic fin);
    ctrl_t c;
    c.mul_en   = mul_en;
    c.mul_sel  = mul_sel;
    c.mul_y    = mul_y;
    c.acc_op   = acc_op;
    c.tap      = tap;
    c.y_ld     = y_ld;
    c.fin_last = fin_last;
    c.fin      = fin;
    return c;
  endfunction

  // microprogram; fin_last ends the item when tap is the last one
  function automatic ctrl_t prog_rom(logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      4'd0:    c = uop(1'b1, REG_B0, 1'b0, ACC_NOP, 2'd0, 1'b0, 1'b0, 1'b0);
      4'd1:    c = uop(1'b0, REG_B0, 1'b0, ACC_OUT, 2'd0, 1'b0, 1'b0, 1'b0);
      4'd2:    c = uop(1'b1, REG_B1, 1'b0, ACC_NOP, 2'd0, 1'b1, 1'b0, 1'b0);
      4'd3:    c = uop(1'b1, REG_A1, 1'b1, ACC_DLY, 2'd1, 1'b0, 1'b0, 1'b0);
      4'd4:    c = uop(1'b1, REG_B2, 1'b0, ACC_WR,  2'd1, 1'b0, 1'b1, 1'b0);
      4'd5:    c = uop(1'b1, REG_A2, 1'b1, ACC_DLY, 2'd2, 1'b0, 1'b0, 1'b0);
      4'd6:    c = uop(1'b1, REG_B3, 1'b0, ACC_WR,  2'd2, 1'b0, 1'b1, 1'b0);
      4'd7:    c = uop(1'b1, REG_A3, 1'b1, ACC_DLY, 2'd3, 1'b0, 1'b0, 1'b0);
      4'd8:    c = uop(1'b0, REG_B0, 1'b0, ACC_WR,  2'd3, 1'b0, 1'b0, 1'b1);
      default: c = uop(1'b0, REG_B0, 1'b0, ACC_NOP, 2'd0, 1'b0, 1'b0, 1'b1);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/iirtdf_in_if.sv
`default_nettype none

interface iirtdf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iirtdf_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/iirtdf_out_if.sv
`default_nettype none

interface iirtdf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iirtdf_pkg::SAMPLE_W-1:0] sample_out;
  logic                                    clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

### hw/rtl/iirtdf_cfg_if.sv
`default_nettype none

interface iirtdf_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [iirtdf_pkg::CFG_IDX_W-1:0]        index;
  logic signed [iirtdf_pkg::COEF_W-1:0]   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/iirtdf_seq.sv
`default_nettype none

module iirtdf_seq #(
  parameter int TAPS = iirtdf_pkg::TAPS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              out_free,
  output iirtdf_pkg::step_t      step,
  output logic                   busy,
  output logic                   done
);

  logic                          busy_r, busy_nxt;
  logic [iirtdf_pkg::PC_W-1:0]   pc_r, pc_nxt;
  iirtdf_pkg::ctrl_t             ctrl_w;
  logic                          is_end;

  assign ctrl_w = iirtdf_pkg::prog_rom(pc_r);
  assign is_end = ctrl_w.fin || (ctrl_w.fin_last && (ctrl_w.tap == 2'(TAPS - 1)));

  // final step waits until the output register can take the result
  assign step.ctrl = ctrl_w;
  assign step.en   = busy_r && !(is_end && !out_free);
  assign done      = step.en && is_end;
  assign busy      = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (step.en) begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/iirtdf_dp.sv
`default_nettype none

module iirtdf_dp #(
  parameter int TAPS = iirtdf_pkg::TAPS_DEFAULT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    load,
  input  wire logic signed [iirtdf_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                                    cfg_we,
  input  wire logic [iirtdf_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire logic signed [iirtdf_pkg::COEF_W-1:0]   cfg_data,
  input  iirtdf_pkg::step_t                            step,
  output logic signed [iirtdf_pkg::SAMPLE_W-1:0]      y,
  output logic                                         clip
);

  localparam int SW = iirtdf_pkg::SAMPLE_W;
  localparam int CW = iirtdf_pkg::COEF_W;
  localparam int PW = iirtdf_pkg::PROD_W;
  localparam int DW = iirtdf_pkg::DLY_W;
  localparam int AW = iirtdf_pkg::ACC_W;
  localparam int YW = iirtdf_pkg::YSH_W;
  localparam int IW = iirtdf_pkg::CFG_IDX_W;

  localparam logic signed [AW-1:0] RND     = AW'(1) <<< (iirtdf_pkg::FRAC - 1);
  localparam logic signed [AW-1:0] DLY_MAX = (AW'(1) <<< (DW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] DLY_MIN = -(AW'(1) <<< (DW - 1));
  localparam logic signed [YW-1:0] Y_MAX   = (YW'(1) <<< (SW - 1)) - YW'(1);
  localparam logic signed [YW-1:0] Y_MIN   = -(YW'(1) <<< (SW - 1));

  logic signed [CW-1:0] coef_r [iirtdf_pkg::NUM_COEF];
  logic signed [DW-1:0] dly_r  [iirtdf_pkg::NUM_DLY];
  logic signed [SW-1:0] x_r;
  logic signed [SW-1:0] y_r;
  logic                 clip_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;

  logic signed [CW-1:0] coef_rd;
  logic signed [SW-1:0] mul_op;
  logic signed [DW-1:0] dly_rd;
  logic signed [DW-1:0] dly_sel;
  logic signed [AW-1:0] diff;
  logic signed [DW-1:0] dly_clamp;
  logic signed [YW-1:0] ysh;
  logic [1:0]           wr_idx;
  iirtdf_pkg::ctrl_t    c;

  assign c = step.ctrl;

  always_comb begin
    case (c.mul_sel)
      iirtdf_pkg::REG_B0: coef_rd = coef_r[0];
      iirtdf_pkg::REG_B1: coef_rd = coef_r[1];
      iirtdf_pkg::REG_B2: coef_rd = coef_r[2];
      iirtdf_pkg::REG_B3: coef_rd = coef_r[3];
      iirtdf_pkg::REG_A1: coef_rd = coef_r[4];
      iirtdf_pkg::REG_A2: coef_rd = coef_r[5];
      iirtdf_pkg::REG_A3: coef_rd = coef_r[6];
      default:            coef_rd = '0;
    endcase
  end

  always_comb begin
    case (c.tap)
      2'd0:    dly_rd = dly_r[0];
      2'd1:    dly_rd = dly_r[1];
      2'd2:    dly_rd = dly_r[2];
      default: dly_rd = '0;
    endcase
  end

  // the last delay tap has no successor
  assign dly_sel   = (c.tap >= 2'(TAPS - 1)) ? '0 : dly_rd;
  assign mul_op    = c.mul_y ? y_r : x_r;
  assign diff      = acc_r - AW'(prod_r);
  assign dly_clamp = (diff > DLY_MAX) ? DW'(DLY_MAX) :
                     (diff < DLY_MIN) ? DW'(DLY_MIN) : DW'(diff);
  assign ysh       = YW'(acc_r >>> iirtdf_pkg::FRAC);
  assign wr_idx    = c.tap - 2'd1;

  assign y    = y_r;
  assign clip = clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= iirtdf_pkg::COEF_ONE;
      for (int i = 1; i < iirtdf_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
      for (int i = 0; i < iirtdf_pkg::NUM_DLY; i++) begin
        dly_r[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_idx < IW'(iirtdf_pkg::NUM_COEF))) begin
        coef_r[cfg_idx] <= cfg_data;
      end
      if (step.en && (c.acc_op == iirtdf_pkg::ACC_WR)) begin
        dly_r[wr_idx] <= dly_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= sample_in;
    end
    if (step.en) begin
      if (c.mul_en) begin
        prod_r <= PW'(coef_rd * mul_op);
      end
      case (c.acc_op)
        iirtdf_pkg::ACC_OUT: acc_r <= AW'(prod_r) + AW'(dly_r[0]) + RND;
        iirtdf_pkg::ACC_DLY: acc_r <= AW'(prod_r) + AW'(dly_sel);
        default:             acc_r <= acc_r;
      endcase
      if (c.y_ld) begin
        if (ysh > Y_MAX) begin
          y_r    <= SW'(Y_MAX);
          clip_r <= 1'b1;
        end else if (ysh < Y_MIN) begin
          y_r    <= SW'(Y_MIN);
          clip_r <= 1'b1;
        end else begin
          y_r    <= SW'(ysh);
          clip_r <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/iir_filter_transposed_df2_core.sv
`default_nettype none

// Third-order (TAPS coefficients per side) IIR filter, transposed direct form II.
// Channels: in_chan carries one signed 16-bit sample per item; out_chan returns
// one item per input with the rounded, saturated sample and a clipped flag;
// cfg_chan writes coefficient registers 0..6 (b0..b3, a1..a3, signed Q3.14).
// cfg_chan is always ready; write only while the filter is idle.
// Each item runs a microprogram on one 18x16 multiplier and one accumulator:
// 2*TAPS+1 steps. in_chan.ready rises the cycle after the last step, so a new
// item is accepted only once the previous one is through; its steps share the
// multiplier and the single delay-line write port.
// A finished result sits in the output register while the next item is taken.
// If out_chan stalls, the next item halts at its final step until the output
// register frees up, and no further item is accepted meanwhile.
// Reset (rst_n low, synchronous) clears the delay line, sets b0 = 1.0 and all
// other coefficients to zero, and empties the output register.
module iir_filter_transposed_df2_core #(
  parameter int TAPS = iirtdf_pkg::TAPS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  iirtdf_in_if.sink     in_chan,
  iirtdf_out_if.source  out_chan,
  iirtdf_cfg_if.sink    cfg_chan
);

  localparam int SW = iirtdf_pkg::SAMPLE_W;

  iirtdf_pkg::step_t     step;
  logic                  busy;
  logic                  done;
  logic                  start;
  logic                  out_free;
  logic signed [SW-1:0]  y;
  logic                  clip;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]  out_sample_r;
  logic                  out_clip_r;

  assign in_chan.ready  = !busy;
  assign start          = in_chan.valid && !busy;
  assign cfg_chan.ready = 1'b1;
  assign out_free       = !out_valid_r || out_chan.ready;

  iirtdf_seq #(.TAPS(TAPS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .step     (step),
    .busy     (busy),
    .done     (done)
  );

  iirtdf_dp #(.TAPS(TAPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (start),
    .sample_in (in_chan.sample_in),
    .cfg_we    (cfg_chan.valid),
    .cfg_idx   (cfg_chan.index),
    .cfg_data  (cfg_chan.wdata),
    .step      (step),
    .y         (y),
    .clip      (clip)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_sample_r <= y;
      out_clip_r   <= clip;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.clipped    = out_clip_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("filter not busy after accepting an item");

  a_done_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_free)
    else $error("result finished into an occupied output register");

  a_done_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r && !busy)
    else $error("finished item not presented or sequencer still busy");

  a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy && !start)
    else $error("sequencer finished while idle");
`endif

endmodule

`default_nettype wire
